// ===== src/sdrd_pkg.sv =====
// Shared types and constants for the SD card SPI single-block read receiver.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package sdrd_pkg;

   // read-one-block command (CMD17) framing
   localparam logic [7:0] CMD_PREFIX = 8'h40;
   localparam logic [7:0] CMD_INDEX  = 8'd17;
   localparam logic [7:0] CMD_FIRST  = CMD_PREFIX + CMD_INDEX;
   localparam logic [7:0] CMD_CRC    = 8'hFF;
   localparam logic [7:0] DATA_TOKEN = 8'hFE;
   localparam logic [2:0] CMD_BEATS  = 3'd6;

   localparam logic [15:0] TIMEOUT_RESET = 16'd8192;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_RESP = 2'd1,
      PH_HUNT = 2'd2,
      PH_DATA = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_RESP = 2'd1,
      ST_R1_ERR  = 2'd2,
      ST_TIMEOUT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RK_CMD    = 2'd0,
      RK_DATA   = 2'd1,
      RK_STATUS = 2'd2
   } rsp_kind_type;

   // work handed from front to back; each expands into one to six beats
   typedef enum logic [1:0] {
      JOB_CMD         = 2'd0,
      JOB_DATA        = 2'd1,
      JOB_DATA_STATUS = 2'd2,
      JOB_STATUS      = 2'd3
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [31:0]  word;    // block address, or data byte in [7:0]
      logic [8:0]   index;
      status_type   status;
   } job_type;

endpackage

`default_nettype wire

// ===== src/sdrd_front.sv =====
// Front end: takes request beats, tracks the read phase and counters, and
// pushes one job per item that produces results. Depends on sdrd_pkg.
`default_nettype none

module sdrd_front #(
   parameter int BLOCK_BYTES    = 512,
   parameter int RESPONSE_TRIES = 64
) (
   input  wire             clock,
   input  wire             reset,
   input  wire             accept,
   input  wire             mode,
   input  wire [31:0]      block_address,
   input  wire [7:0]       rx_byte,
   input  wire             csr_valid,
   input  wire [15:0]      csr_data,
   output logic            push,
   output sdrd_pkg::job_type job
);

   localparam int TW = $clog2(RESPONSE_TRIES + 1);
   localparam int IW = $clog2(BLOCK_BYTES + 1);

   sdrd_pkg::phase_type phase_ff, phase_in;
   logic [TW-1:0]       tries_ff, tries_in;
   logic [15:0]         count_ff, count_in;
   logic [IW-1:0]       index_ff, index_in;
   logic [15:0]         timeout_ff;
   logic [IW+8:0]       index_ext;

   assign index_ext = {9'd0, index_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= sdrd_pkg::PH_IDLE;
         tries_ff   <= '0;
         count_ff   <= '0;
         index_ff   <= '0;
         timeout_ff <= sdrd_pkg::TIMEOUT_RESET;
      end else begin
         phase_ff <= phase_in;
         tries_ff <= tries_in;
         count_ff <= count_in;
         index_ff <= index_in;
         if (csr_valid) begin
            timeout_ff <= csr_data;
         end
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      tries_in   = tries_ff;
      count_in   = count_ff;
      index_in   = index_ff;
      push       = 1'b0;
      job.kind   = sdrd_pkg::JOB_STATUS;
      job.word   = '0;
      job.index  = '0;
      job.status = sdrd_pkg::ST_OK;
      if (accept) begin
         if (!mode) begin
            push     = 1'b1;
            job.kind = sdrd_pkg::JOB_CMD;
            job.word = block_address;
            phase_in = sdrd_pkg::PH_RESP;
            tries_in = '0;
            count_in = '0;
            index_in = '0;
         end else begin
            case (phase_ff)
               sdrd_pkg::PH_RESP: begin
                  tries_in = tries_ff + TW'(1);
                  if (!rx_byte[7]) begin
                     if (rx_byte != 8'd0) begin
                        phase_in   = sdrd_pkg::PH_IDLE;
                        push       = 1'b1;
                        job.status = sdrd_pkg::ST_R1_ERR;
                     end else begin
                        phase_in = sdrd_pkg::PH_HUNT;
                     end
                  end else if (tries_in >= TW'(RESPONSE_TRIES)) begin
                     phase_in   = sdrd_pkg::PH_IDLE;
                     push       = 1'b1;
                     job.status = sdrd_pkg::ST_NO_RESP;
                  end
               end
               sdrd_pkg::PH_HUNT: begin
                  count_in = count_ff + 16'd1;
                  if (rx_byte == sdrd_pkg::DATA_TOKEN) begin
                     phase_in = sdrd_pkg::PH_DATA;
                  end
                  // token on the last allowed byte still times out
                  if (count_in >= timeout_ff) begin
                     phase_in   = sdrd_pkg::PH_IDLE;
                     push       = 1'b1;
                     job.status = sdrd_pkg::ST_TIMEOUT;
                  end
               end
               sdrd_pkg::PH_DATA: begin
                  count_in  = count_ff + 16'd1;
                  index_in  = index_ff + IW'(1);
                  push      = 1'b1;
                  job.word  = {24'd0, rx_byte};
                  job.index = index_ext[8:0];
                  if (index_in >= IW'(BLOCK_BYTES)) begin
                     phase_in   = sdrd_pkg::PH_IDLE;
                     job.kind   = sdrd_pkg::JOB_DATA_STATUS;
                     job.status = sdrd_pkg::ST_OK;
                  end else if (count_in >= timeout_ff) begin
                     phase_in   = sdrd_pkg::PH_IDLE;
                     job.kind   = sdrd_pkg::JOB_DATA_STATUS;
                     job.status = sdrd_pkg::ST_TIMEOUT;
                  end else begin
                     job.kind = sdrd_pkg::JOB_DATA;
                  end
               end
               default: begin
                  // byte while idle: dropped
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/sdrd_queue.sv =====
// Short job queue between front and back, register array with wrap pointers.
// Depends on sdrd_pkg for the job type.
`default_nettype none

module sdrd_queue #(
   parameter int DEPTH = 4
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  sdrd_pkg::job_type push_job,
   output logic              full,
   input  wire               pop,
   output logic              head_valid,
   output sdrd_pkg::job_type head_job
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   sdrd_pkg::job_type entry_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]     count_ff;
   logic              do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + CW'(1);
            2'b01:   count_ff <= count_ff - CW'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== src/sdrd_back.sv =====
// Back end: expands queued jobs into response beats through an output register.
// Depends on sdrd_pkg.
`default_nettype none

module sdrd_back (
   input  wire               clock,
   input  wire               reset,
   input  wire               head_valid,
   input  sdrd_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output logic [7:0]        rsp_value,
   output logic [8:0]        rsp_index,
   output logic [1:0]        rsp_status,
   output logic [1:0]        rsp_kind,
   output logic              rsp_last
);

   logic [2:0] beat_ff;
   logic       advance;
   logic       final_beat;
   logic [7:0] value_in, value_ff;
   logic [8:0] index_in, index_ff;
   logic [1:0] status_in, status_ff;
   logic [1:0] kind_in, kind_ff;
   logic       last_in, last_ff;
   logic       valid_ff;

   assign advance    = head_valid && (!valid_ff || rsp_tready);
   assign pop        = advance && final_beat;
   assign rsp_tvalid = valid_ff;
   assign rsp_value  = value_ff;
   assign rsp_index  = index_ff;
   assign rsp_status = status_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_last   = last_ff;

   always_comb begin
      value_in   = '0;
      index_in   = '0;
      status_in  = sdrd_pkg::ST_OK;
      kind_in    = sdrd_pkg::RK_STATUS;
      last_in    = 1'b1;
      final_beat = 1'b1;
      case (head_job.kind)
         sdrd_pkg::JOB_CMD: begin
            kind_in    = sdrd_pkg::RK_CMD;
            index_in   = {6'd0, beat_ff};
            final_beat = (beat_ff == sdrd_pkg::CMD_BEATS - 3'd1);
            last_in    = final_beat;
            case (beat_ff)
               3'd0:    value_in = sdrd_pkg::CMD_FIRST;
               3'd1:    value_in = head_job.word[31:24];
               3'd2:    value_in = head_job.word[23:16];
               3'd3:    value_in = head_job.word[15:8];
               3'd4:    value_in = head_job.word[7:0];
               default: value_in = sdrd_pkg::CMD_CRC;
            endcase
         end
         sdrd_pkg::JOB_DATA: begin
            kind_in  = sdrd_pkg::RK_DATA;
            value_in = head_job.word[7:0];
            index_in = head_job.index;
         end
         sdrd_pkg::JOB_DATA_STATUS: begin
            if (beat_ff == 3'd0) begin
               kind_in    = sdrd_pkg::RK_DATA;
               value_in   = head_job.word[7:0];
               index_in   = head_job.index;
               last_in    = 1'b0;
               final_beat = 1'b0;
            end else begin
               status_in = head_job.status;
            end
         end
         default: begin
            status_in = head_job.status;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         value_ff  <= value_in;
         index_ff  <= index_in;
         status_ff <= status_in;
         kind_ff   <= kind_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= '0;
      end else begin
         if (advance) begin
            valid_ff <= 1'b1;
            beat_ff  <= final_beat ? 3'd0 : beat_ff + 3'd1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/sd_spi_block_read_receiver.sv =====
// Host-side SD card SPI single-block read sequencer, top level.
// Instantiates sdrd_front, sdrd_queue and sdrd_back; depends on sdrd_pkg.
//
// Usage:
//   req_* takes one beat per item: tuser 0 starts a read of the block in
//   tdata[31:0], tuser 1 hands over one byte received from the card in
//   tdata[39:32]. rsp_* returns the six CMD17 bytes to transmit, each data
//   byte of the block with its index, and one status beat per run that fails or
//   completes; tlast marks the final beat caused by one request beat.
//   csr_* writes the hunt-and-data byte limit (reset 8192); write it only idle.
// Timing:
//   The front takes one request beat per cycle unless the job queue is full.
//   The first response beat of an item passes the job queue, then the output
//   register. The back emits one beat per cycle while rsp_tready is high, so
//   a start item holds the output for all its CMD17 beats; a four-deep job
//   queue lets the front run ahead meanwhile, and req_tready drops only while
//   that queue is full. Bytes that cause no response use no queue space.
// Reset (synchronous): phase idle, counters cleared, queue and output empty.
// A stalled rsp_tready holds the output beat; the queue fills, then req stalls.
`default_nettype none

module sd_spi_block_read_receiver #(
   parameter int BLOCK_BYTES    = 512,
   parameter int RESPONSE_TRIES = 64,
   parameter int QUEUE_DEPTH    = 4
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // block_address[31:0], rx_byte[39:32]
   input  wire         req_tuser,   // mode
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // value[7:0], byte_index[16:8], status[18:17]
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [15:0] csr_data
);

   logic              accept;
   logic              push;
   sdrd_pkg::job_type push_job;
   logic              full;
   logic              pop;
   logic              head_valid;
   sdrd_pkg::job_type head_job;
   logic [7:0]        rsp_value;
   logic [8:0]        rsp_index;
   logic [1:0]        rsp_status;

   assign req_tready = !full;
   assign accept     = req_tvalid && !full;
   assign csr_ready  = 1'b1;
   assign rsp_tdata  = {5'd0, rsp_status, rsp_index, rsp_value};

   sdrd_front #(
      .BLOCK_BYTES    (BLOCK_BYTES),
      .RESPONSE_TRIES (RESPONSE_TRIES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .mode          (req_tuser),
      .block_address (req_tdata[31:0]),
      .rx_byte       (req_tdata[39:32]),
      .csr_valid     (csr_valid),
      .csr_data      (csr_data),
      .push          (push),
      .job           (push_job)
   );

   sdrd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   sdrd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_index  (rsp_index),
      .rsp_status (rsp_status),
      .rsp_kind   (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== bench/tb_sd_spi_block_read_receiver.sv =====
// Self-checking bench for the SD SPI single-block read receiver: CMD17 framing,
// R1 wait, token hunt, data beats and status beats checked against a local FSM.
// Depends on sdrd_pkg and sd_spi_block_read_receiver.
`default_nettype none

module tb_sd_spi_block_read_receiver;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BLOCK_BYTES    = 512;
   localparam int RESPONSE_TRIES = 64;
   localparam int QUIET_LIMIT    = 2000;
   localparam int SETTLE_CYCLES  = 8;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_BYTE  = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [31:0] addr;
      logic [7:0]  rx;
   } host_item_type;

   typedef struct packed {
      sdrd_pkg::rsp_kind_type kind;
      logic [7:0]             value;
      logic [8:0]             idx;
      sdrd_pkg::status_type   status;
      logic                   last;
   } sd_beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data   = '0;

   sd_spi_block_read_receiver #(
      .BLOCK_BYTES    (BLOCK_BYTES),
      .RESPONSE_TRIES (RESPONSE_TRIES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   host_item_type host_items[$];
   sd_beat_type   sd_beats_due[$];
   int            queued_items  = 0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   int            mismatches    = 0;
   int            quiet_cycles  = 0;
   logic          req_beat_done = 1'b0;

   // local copy of the read sequencer state
   sdrd_pkg::phase_type rd_phase   = sdrd_pkg::PH_IDLE;
   int                  resp_tries = 0;
   int                  data_count = 0;
   int                  blk_index  = 0;
   int                  lim_bytes  = sdrd_pkg::TIMEOUT_RESET;

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic sd_beat_type status_beat(input sdrd_pkg::status_type st);
      return '{kind: sdrd_pkg::RK_STATUS, value: 8'h00, idx: 9'd0, status: st, last: 1'b1};
   endfunction

   // advance the read FSM by one accepted beat, queue the beats it produces
   task automatic advance_read_fsm(input host_item_type it);
      sd_beat_type b;
      if (it.mode == MODE_START) begin
         for (int i = 0; i < 6; i++) begin
            b.kind   = sdrd_pkg::RK_CMD;
            b.idx    = 9'(i);
            b.status = sdrd_pkg::ST_OK;
            b.last   = (i == 5);
            case (i)
               0: b.value = sdrd_pkg::CMD_FIRST;
               5: b.value = sdrd_pkg::CMD_CRC;
               default: b.value = 8'(it.addr >> (8 * (4 - i)));
            endcase
            sd_beats_due.push_back(b);
         end
         rd_phase   = sdrd_pkg::PH_RESP;
         resp_tries = 0;
         data_count = 0;
         blk_index  = 0;
      end else begin
         case (rd_phase)
            sdrd_pkg::PH_RESP: begin
               resp_tries++;
               if (!it.rx[7]) begin
                  if (it.rx != 8'h00) begin
                     rd_phase = sdrd_pkg::PH_IDLE;
                     sd_beats_due.push_back(status_beat(sdrd_pkg::ST_R1_ERR));
                  end else begin
                     rd_phase = sdrd_pkg::PH_HUNT;
                  end
               end else if (resp_tries >= RESPONSE_TRIES) begin
                  rd_phase = sdrd_pkg::PH_IDLE;
                  sd_beats_due.push_back(status_beat(sdrd_pkg::ST_NO_RESP));
               end
            end
            sdrd_pkg::PH_HUNT: begin
               data_count++;
               if (it.rx == sdrd_pkg::DATA_TOKEN) rd_phase = sdrd_pkg::PH_DATA;
               // a token on the last allowed byte still times out
               if (data_count >= lim_bytes) begin
                  rd_phase = sdrd_pkg::PH_IDLE;
                  sd_beats_due.push_back(status_beat(sdrd_pkg::ST_TIMEOUT));
               end
            end
            sdrd_pkg::PH_DATA: begin
               data_count++;
               b = '{kind: sdrd_pkg::RK_DATA, value: it.rx, idx: 9'(blk_index),
                     status: sdrd_pkg::ST_OK, last: 1'b0};
               blk_index++;
               if (blk_index >= BLOCK_BYTES) begin
                  rd_phase = sdrd_pkg::PH_IDLE;
                  sd_beats_due.push_back(b);
                  sd_beats_due.push_back(status_beat(sdrd_pkg::ST_OK));
               end else if (data_count >= lim_bytes) begin
                  rd_phase = sdrd_pkg::PH_IDLE;
                  sd_beats_due.push_back(b);
                  sd_beats_due.push_back(status_beat(sdrd_pkg::ST_TIMEOUT));
               end else begin
                  b.last = 1'b1;
                  sd_beats_due.push_back(b);
               end
            end
            default: ;
         endcase
      end
   endtask

   // driver: new beat or hold at the falling edge
   always @(negedge clock) begin : driver
      host_item_type nxt;
      logic          nvalid;
      nvalid = req_tvalid;
      if (reset) begin
         nvalid = 1'b0;
      end else if (!req_tvalid || req_beat_done) begin
         nvalid = 1'b0;
         if (host_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt    = host_items.pop_front();
            nvalid = 1'b1;
            req_tdata <= {nxt.rx, nxt.addr};
            req_tuser <= nxt.mode;
         end
      end
      req_tvalid <= nvalid;
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor: accepted request beats feed the FSM, response beats are checked
   always @(posedge clock) begin : monitor
      sd_beat_type want;
      req_beat_done <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready)
            advance_read_fsm('{mode: req_tuser, addr: req_tdata[31:0], rx: req_tdata[39:32]});
         if (rsp_tvalid && rsp_tready) begin
            if (sd_beats_due.size() == 0) begin
               report_mismatch($sformatf("unexpected beat kind=%0d data=%h last=%b",
                                         rsp_tuser, rsp_tdata, rsp_tlast));
            end else begin
               want = sd_beats_due.pop_front();
               if (rsp_tuser !== want.kind)
                  report_mismatch($sformatf("kind %0d, want %0d", rsp_tuser, want.kind));
               if (rsp_tdata[7:0] !== want.value)
                  report_mismatch($sformatf("value %h, want %h", rsp_tdata[7:0], want.value));
               if (rsp_tdata[16:8] !== want.idx)
                  report_mismatch($sformatf("byte_index %0d, want %0d",
                                            rsp_tdata[16:8], want.idx));
               if (rsp_tdata[18:17] !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_tdata[18:17], want.status));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("tlast %b, want %b", rsp_tlast, want.last));
            end
         end
      end
   end

   // watchdog: only cycles with no beat on any channel count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         report_mismatch($sformatf("watchdog: no beat for %0d cycles", QUIET_LIMIT));
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void send_start(input logic [31:0] addr);
      host_items.push_back('{mode: MODE_START, addr: addr, rx: 8'($urandom())});
      queued_items++;
   endfunction

   function automatic void send_byte(input logic [7:0] rx);
      host_items.push_back('{mode: MODE_BYTE, addr: $urandom(), rx: rx});
      queued_items++;
   endfunction

   // start, busy fill bytes, R1, and on a zero R1 hunt bytes, token and data
   function automatic void queue_read_run(input int n_fill, input logic [7:0] r1,
                                          input int n_hunt, input int n_data);
      logic [7:0] hb;
      send_start($urandom());
      repeat (n_fill) send_byte(8'h80 | 8'($urandom()));
      send_byte(r1);
      if (r1 == 8'h00) begin
         repeat (n_hunt) begin
            hb = 8'($urandom());
            if (hb == sdrd_pkg::DATA_TOKEN) hb = 8'hFF;
            send_byte(hb);
         end
         send_byte(sdrd_pkg::DATA_TOKEN);
         repeat (n_data) send_byte(8'($urandom()));
      end
   endfunction

   task automatic wait_quiet();
      while (host_items.size() != 0 || req_tvalid || sd_beats_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      lim_bytes = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed runs with random content, some cut short, some stray bytes
   task automatic random_reads(input int n_items);
      int target;
      int pick;
      target = queued_items + n_items;
      while (queued_items < target) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            queue_read_run(($urandom_range(9) == 0) ? $urandom_range(40, 70)
                                                    : $urandom_range(0, 4),
                           ($urandom_range(7) == 0) ? 8'($urandom_range(1, 127)) : 8'h00,
                           $urandom_range(0, 6), $urandom_range(0, 40));
         end else if (pick < 90) begin
            send_start($urandom());
            repeat ($urandom_range(0, 12)) send_byte(8'($urandom()));
         end else begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom()));
         end
      end
      // close with an R1 error so the block ends idle
      send_start($urandom());
      send_byte(8'h01);
      wait_quiet();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 34;
      recv_idle_pct = 50;

      // stray bytes before any start are ignored
      send_byte(8'h00);
      send_byte(8'hFF);
      send_start(32'h0000_0000);
      send_byte(8'h80);
      send_byte(8'h01);
      send_start(32'hFFFF_FFFF);
      send_byte(8'h7F);
      // restart while waiting for R1, then while receiving data
      send_start(32'h1234_5678);
      send_start(32'h9ABC_DEF0);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(sdrd_pkg::DATA_TOKEN);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(sdrd_pkg::DATA_TOKEN);
      send_start(32'hA5A5_A5A5);
      send_byte(8'h00);
      send_byte(sdrd_pkg::DATA_TOKEN);
      send_byte(8'h55);
      send_start(32'h0000_0001);
      send_byte(8'h40);
      wait_quiet();

      // limit 1: token on the only allowed byte, then a plain hunt byte
      write_limit(16'd1);
      queue_read_run(0, 8'h00, 0, 0);
      send_start($urandom());
      send_byte(8'h00);
      send_byte(8'h12);
      wait_quiet();
      // limit 0: first hunt byte times out
      write_limit(16'd0);
      queue_read_run(1, 8'h00, 0, 0);
      wait_quiet();
      // limit 2: one data beat, then timeout
      write_limit(16'd2);
      queue_read_run(0, 8'h00, 0, 1);
      wait_quiet();

      write_limit(16'($urandom_range(2, 60)));
      // pause the sender mid data phase until every beat is back
      queue_read_run(0, 8'h00, 1, 5);
      wait_quiet();
      repeat (5) send_byte(8'($urandom()));
      random_reads(30);

      send_idle_pct = 50;
      recv_idle_pct = 34;
      // R1 on the last try, then a full block whose last byte lands on the limit
      write_limit(16'(BLOCK_BYTES + 3));
      queue_read_run(RESPONSE_TRIES - 1, 8'h00, 2, BLOCK_BYTES);
      // no R1 at all; the trailing bytes land while idle
      queue_read_run(RESPONSE_TRIES, 8'h00, 0, 0);
      wait_quiet();
      write_limit(16'($urandom_range(10, 120)));
      random_reads(30);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_limit(16'($urandom_range(20, 600)));
      random_reads(30);

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
